[rtl/core/mpch_pkg.sv]
// Shared types, constants and the arctangent table of the marker pair heading block.
`timescale 1ns / 1ps
`default_nettype none
package mpch_pkg;

   localparam int COORD_BITS   = 16;
   localparam int CENTER_BITS  = COORD_BITS + 1;
   localparam int HEADING_BITS = 16;
   localparam int MAX_STAGES   = 24;
   localparam int STAGE_IDX_BITS = $clog2(MAX_STAGES);
   // Angle accumulator in signed degrees with 16 fraction bits.
   localparam int ANGLE_BITS   = 26;
   localparam int ROUND_SHIFT  = 9;

   localparam logic signed [ANGLE_BITS-1:0] QUARTER_TURN_Q16 = ANGLE_BITS'(5898240);
   localparam logic signed [ANGLE_BITS-1:0] FULL_TURN_Q16    = ANGLE_BITS'(23592960);
   localparam logic signed [ANGLE_BITS-1:0] ROUND_HALF_Q16   = ANGLE_BITS'(256);
   localparam logic [HEADING_BITS:0]        FULL_TURN_Q7     = (HEADING_BITS+1)'(46080);
   localparam logic [HEADING_BITS-1:0]      HALF_TURN_Q7     = HEADING_BITS'(23040);

   typedef struct packed {
      logic [COORD_BITS-1:0] ident_x;
      logic [COORD_BITS-1:0] ident_y;
      logic [COORD_BITS-1:0] front_x;
      logic [COORD_BITS-1:0] front_y;
   } req_type;

   typedef struct packed {
      logic [CENTER_BITS-1:0]  center_x;
      logic [CENTER_BITS-1:0]  center_y;
      logic [HEADING_BITS-1:0] heading;
   } rsp_type;

   // Everything that rides along the cell chain besides the vector itself.
   typedef struct packed {
      logic                          valid;
      logic                          same_point;
      logic signed [ANGLE_BITS-1:0]  angle;
      logic [CENTER_BITS-1:0]        center_x;
      logic [CENTER_BITS-1:0]        center_y;
   } cell_ctl_type;

   // atan(2^-i) in degrees, rounded to the nearest 2^-16.
   function automatic logic signed [ANGLE_BITS-1:0] atan_deg_q16(
      input logic [STAGE_IDX_BITS-1:0] idx);
      logic signed [ANGLE_BITS-1:0] val;
      case (idx)
         5'd0:    val = ANGLE_BITS'(2949120);
         5'd1:    val = ANGLE_BITS'(1740967);
         5'd2:    val = ANGLE_BITS'(919879);
         5'd3:    val = ANGLE_BITS'(466945);
         5'd4:    val = ANGLE_BITS'(234379);
         5'd5:    val = ANGLE_BITS'(117304);
         5'd6:    val = ANGLE_BITS'(58666);
         5'd7:    val = ANGLE_BITS'(29335);
         5'd8:    val = ANGLE_BITS'(14668);
         5'd9:    val = ANGLE_BITS'(7334);
         5'd10:   val = ANGLE_BITS'(3667);
         5'd11:   val = ANGLE_BITS'(1833);
         5'd12:   val = ANGLE_BITS'(917);
         5'd13:   val = ANGLE_BITS'(458);
         5'd14:   val = ANGLE_BITS'(229);
         5'd15:   val = ANGLE_BITS'(115);
         5'd16:   val = ANGLE_BITS'(57);
         5'd17:   val = ANGLE_BITS'(29);
         5'd18:   val = ANGLE_BITS'(14);
         5'd19:   val = ANGLE_BITS'(7);
         5'd20:   val = ANGLE_BITS'(4);
         5'd21:   val = ANGLE_BITS'(2);
         5'd22:   val = ANGLE_BITS'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

[rtl/core/marker_pair_center_heading.sv]
// Top level of the marker pair midpoint and heading block: entry stage, cell chain, exit stage.
// Each item is registered in the entry stage, in every cell and in the exit stage.
// Throughput: one item per cycle; busy is always low, because every stage is a register
// that hands its item to the next one each cycle and the receiver cannot stall.
// Reset clears the control words of the entry stage and the cells and the exit strobe.
// Items in flight at reset are dropped; no result strobe appears until new items arrive.
`timescale 1ns / 1ps
`default_nettype none
module marker_pair_center_heading import mpch_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   // The coordinates are scaled up by enough guard bits that the truncating shifts in the
   // cells lose nothing that the angle would notice. The vector width leaves room for the
   // difference (COORD_BITS + 1 signed bits), the CORDIC gain of about 1.65, the diagonal
   // factor of the pre-rotation, and the guard bits.
   localparam int GUARD_BITS = CORDIC_STAGES + 2;
   localparam int VEC_BITS   = COORD_BITS + 3 + GUARD_BITS;

   // Position k of the chain is the output of the entry stage (k = 0) or of cell k - 1.
   logic signed [VEC_BITS-1:0] chain_x [0:CORDIC_STAGES];
   logic signed [VEC_BITS-1:0] chain_y [0:CORDIC_STAGES];
   cell_ctl_type               chain_ctl [0:CORDIC_STAGES];

   // Every stage moves each cycle, so the block is never busy.
   assign busy = 1'b0;

   mpch_front #(
      .GUARD_BITS (GUARD_BITS),
      .VEC_BITS   (VEC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (start),
      .req_data (req_data),
      .vec_x    (chain_x[0]),
      .vec_y    (chain_y[0]),
      .ctl_out  (chain_ctl[0])
   );

   // The row of rotation cells: cell k applies the shift by k and the k-th arctangent.
   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
      mpch_cell #(
         .STAGE    (k),
         .VEC_BITS (VEC_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .x_in_vec  (chain_x[k]),
         .y_in_vec  (chain_y[k]),
         .ctl_prev  (chain_ctl[k]),
         .x_out_vec (chain_x[k+1]),
         .y_out_vec (chain_y[k+1]),
         .ctl_next  (chain_ctl[k+1])
      );
   end

   // The final vector is not needed; only the accumulated angle leaves the chain.
   mpch_back u_back (
      .clock      (clock),
      .reset      (reset),
      .ctl_last   (chain_ctl[CORDIC_STAGES]),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

[rtl/core/mpch_front.sv]
// Entry stage: midpoint sums, difference vector, guard scaling and quadrant pre-rotation.
`timescale 1ns / 1ps
`default_nettype none
module mpch_front import mpch_pkg::*; #(
   parameter int GUARD_BITS = 18,
   parameter int VEC_BITS   = 39
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        take,
   input  wire req_type                     req_data,
   output logic signed [VEC_BITS-1:0]       vec_x,
   output logic signed [VEC_BITS-1:0]       vec_y,
   output cell_ctl_type                     ctl_out
);

   logic signed [COORD_BITS:0]   dx;
   logic signed [COORD_BITS:0]   dy;
   logic signed [VEC_BITS-1:0]   raw_x;
   logic signed [VEC_BITS-1:0]   raw_y;
   logic signed [VEC_BITS-1:0]   vec_x_in;
   logic signed [VEC_BITS-1:0]   vec_y_in;
   logic signed [VEC_BITS-1:0]   vec_x_ff;
   logic signed [VEC_BITS-1:0]   vec_y_ff;
   cell_ctl_type                 ctl_in;
   cell_ctl_type                 ctl_ff;

   always_comb begin
      dx = signed'({1'b0, req_data.front_x}) - signed'({1'b0, req_data.ident_x});
      dy = signed'({1'b0, req_data.front_y}) - signed'({1'b0, req_data.ident_y});
      // The vector is (-dy, dx) so that zero degrees points up the image.
      raw_x = -(VEC_BITS'(dy) <<< GUARD_BITS);
      raw_y = VEC_BITS'(dx) <<< GUARD_BITS;

      ctl_in.valid      = take;
      ctl_in.same_point = (dx == '0) && (dy == '0);
      ctl_in.center_x   = CENTER_BITS'(req_data.ident_x) + CENTER_BITS'(req_data.front_x);
      ctl_in.center_y   = CENTER_BITS'(req_data.ident_y) + CENTER_BITS'(req_data.front_y);

      // Fold the left half plane onto the right one so the cells converge.
      if (raw_x < 0) begin
         if (raw_y >= 0) begin
            vec_x_in     = raw_y;
            vec_y_in     = -raw_x;
            ctl_in.angle = QUARTER_TURN_Q16;
         end else begin
            vec_x_in     = -raw_y;
            vec_y_in     = raw_x;
            ctl_in.angle = -QUARTER_TURN_Q16;
         end
      end else begin
         vec_x_in     = raw_x;
         vec_y_in     = raw_y;
         ctl_in.angle = '0;
      end
   end

   always_ff @(posedge clock) begin
      vec_x_ff <= vec_x_in;
      vec_y_ff <= vec_y_in;
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   assign vec_x   = vec_x_ff;
   assign vec_y   = vec_y_ff;
   assign ctl_out = ctl_ff;

endmodule
`default_nettype wire

[rtl/core/mpch_cell.sv]
// One vectoring rotation step with its own fixed shift and angle constant.
`timescale 1ns / 1ps
`default_nettype none
module mpch_cell import mpch_pkg::*; #(
   parameter int STAGE    = 0,
   parameter int VEC_BITS = 39
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic signed [VEC_BITS-1:0]  x_in_vec,
   input  wire logic signed [VEC_BITS-1:0]  y_in_vec,
   input  wire cell_ctl_type                ctl_prev,
   output logic signed [VEC_BITS-1:0]       x_out_vec,
   output logic signed [VEC_BITS-1:0]       y_out_vec,
   output cell_ctl_type                     ctl_next
);

   localparam logic signed [ANGLE_BITS-1:0] STEP_ANGLE =
      atan_deg_q16(STAGE_IDX_BITS'(STAGE));

   logic signed [VEC_BITS-1:0] x_shift;
   logic signed [VEC_BITS-1:0] y_shift;
   logic signed [VEC_BITS-1:0] x_in;
   logic signed [VEC_BITS-1:0] y_in;
   logic signed [VEC_BITS-1:0] x_ff;
   logic signed [VEC_BITS-1:0] y_ff;
   cell_ctl_type               ctl_in;
   cell_ctl_type               ctl_ff;

   always_comb begin
      // Arithmetic shift rounds toward minus infinity.
      x_shift = x_in_vec >>> STAGE;
      y_shift = y_in_vec >>> STAGE;
      ctl_in  = ctl_prev;
      if (y_in_vec >= 0) begin
         x_in         = x_in_vec + y_shift;
         y_in         = y_in_vec - x_shift;
         ctl_in.angle = ctl_prev.angle + STEP_ANGLE;
      end else begin
         x_in         = x_in_vec - y_shift;
         y_in         = y_in_vec + x_shift;
         ctl_in.angle = ctl_prev.angle - STEP_ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   assign x_out_vec = x_ff;
   assign y_out_vec = y_ff;
   assign ctl_next  = ctl_ff;

endmodule
`default_nettype wire

[rtl/core/mpch_back.sv]
// Exit stage: wraps the angle into one turn and rounds it to the output heading format.
`timescale 1ns / 1ps
`default_nettype none
module mpch_back import mpch_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_ctl_type ctl_last,
   output logic              rsp_strobe,
   output rsp_type           rsp_data
);

   logic signed [ANGLE_BITS-1:0] angle_pos;
   logic signed [ANGLE_BITS-1:0] angle_rnd;
   logic [HEADING_BITS:0]        heading_full;
   rsp_type                      rsp_in;
   rsp_type                      rsp_ff;
   logic                         strobe_ff;

   always_comb begin
      angle_pos = (ctl_last.angle < 0) ? ctl_last.angle + FULL_TURN_Q16 : ctl_last.angle;
      angle_rnd = angle_pos + ROUND_HALF_Q16;
      heading_full = angle_rnd[ROUND_SHIFT +: (HEADING_BITS + 1)];
      if (heading_full >= FULL_TURN_Q7) begin
         heading_full = heading_full - FULL_TURN_Q7;
      end
      rsp_in.center_x = ctl_last.center_x;
      rsp_in.center_y = ctl_last.center_y;
      // Coinciding points have no direction; they report straight down.
      rsp_in.heading  = ctl_last.same_point ? HALF_TURN_Q7 : heading_full[HEADING_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl_last.valid;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
`default_nettype wire

[tb/marker_pair_center_heading_tb.sv]
// Self-checking testbench for the marker pair midpoint and compass heading block.
`timescale 1ns / 1ps
module marker_pair_center_heading_tb;
   import mpch_pkg::*;

   // The testbench predictor runs the same number of rotation steps as the instance.
   localparam int CORDIC_STAGES = 16;
   // Pipeline depth of the instance: entry stage, cells and exit stage.
   localparam int PIPE_LATENCY  = CORDIC_STAGES + 2;
   localparam int GUARD_SHIFT   = CORDIC_STAGES + 2;
   localparam int MAX_PRINTED   = 100;

   // Angles in degrees, with 16 fraction bits (Q.16) and 7 fraction bits (Q.7).
   localparam longint DEG90_Q16  = 64'sd5898240;
   localparam longint DEG360_Q16 = 64'sd23592960;
   localparam longint DEG360_Q7  = 64'sd46080;
   localparam longint ROUND_Q7   = 64'sd256;
   localparam int     Q16_TO_Q7  = 9;
   localparam logic [HEADING_BITS-1:0] DEG180_Q7 = 16'd23040;

   // Rotation angle of step i, atan(2^-i) in degrees, rounded to the nearest 2^-16.
   localparam longint ARCTAN_STEP_Q16 [0:23] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // Midpoint and heading predictions of accepted items, oldest first.
   rsp_type expected_results[$];

   int mismatch_count;
   int pairs_sent;
   int coincident_sent;
   int results_checked;

   marker_pair_center_heading #(
      .CORDIC_STAGES(CORDIC_STAGES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Safety net: the slowest legal run needs only a small fraction of this time.
   initial begin
      #2_000_000;
      $display("Timeout: the run did not finish, %0d results still pending.",
               expected_results.size());
      $display("[marker_pair_center_heading] ERROR");
      $finish;
   end

   // Compass heading of the vector (dx, dy) in Q.7 degrees, y growing downward.
   // A vectoring CORDIC drives the vector (-dy, dx) onto the positive X axis and
   // accumulates the angle it turned through.
   function automatic logic [HEADING_BITS-1:0] compass_heading_q7(input longint dx,
                                                                 input longint dy);
      longint vec_x;
      longint vec_y;
      longint held;
      longint part_x;
      longint part_y;
      longint angle;
      longint rounded;
      // Coinciding points give the signed-zero arctangent, which points straight down.
      if (dx == 0 && dy == 0) begin
         return DEG180_Q7;
      end
      vec_x = -dy * (64'sd1 <<< GUARD_SHIFT);
      vec_y = dx * (64'sd1 <<< GUARD_SHIFT);
      angle = 0;
      // Vectors in the left half plane are first turned by a quarter turn so that
      // the rotation steps only have to cover +/- 90 degrees.
      if (vec_x < 0) begin
         held = vec_x;
         if (vec_y >= 0) begin
            vec_x = vec_y;
            vec_y = -held;
            angle = DEG90_Q16;
         end else begin
            vec_x = -vec_y;
            vec_y = held;
            angle = -DEG90_Q16;
         end
      end
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
         // Arithmetic shifts of signed values round toward minus infinity.
         part_x = vec_x >>> i;
         part_y = vec_y >>> i;
         if (vec_y >= 0) begin
            vec_x = vec_x + part_y;
            vec_y = vec_y - part_x;
            angle = angle + ARCTAN_STEP_Q16[i];
         end else begin
            vec_x = vec_x - part_y;
            vec_y = vec_y + part_x;
            angle = angle - ARCTAN_STEP_Q16[i];
         end
      end
      if (angle < 0) begin
         angle = angle + DEG360_Q16;
      end
      if (angle < 0) begin
         angle = 0;
      end
      rounded = (angle + ROUND_Q7) >>> Q16_TO_Q7;
      // Rounding can land exactly on a full turn, which reads as north again.
      if (rounded >= DEG360_Q7) begin
         rounded = rounded - DEG360_Q7;
      end
      return rounded[HEADING_BITS-1:0];
   endfunction

   // Expected midpoint sums and heading for one marker pair.
   function automatic rsp_type predict_center_heading(input req_type pair);
      rsp_type outcome;
      longint  rear_x;
      longint  rear_y;
      longint  nose_x;
      longint  nose_y;
      rear_x = pair.ident_x;
      rear_y = pair.ident_y;
      nose_x = pair.front_x;
      nose_y = pair.front_y;
      outcome.center_x = CENTER_BITS'(rear_x + nose_x);
      outcome.center_y = CENTER_BITS'(rear_y + nose_y);
      outcome.heading  = compass_heading_q7(nose_x - rear_x, nose_y - rear_y);
      return outcome;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) begin
         $display("Mismatch at %0t: %s is %0d, expected %0d", $realtime, what, got, want);
      end
   endtask

   // Drives one item at the falling edge and waits for the edge that takes it.
   // Before that the sender may stay quiet for a random number of cycles.
   task automatic send_marker_pair(input req_type pair, input int gap_pct);
      while ($urandom_range(99) < gap_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= pair;
      do @(posedge clock); while (busy);
      expected_results.push_back(predict_center_heading(pair));
      pairs_sent++;
      if (pair.ident_x == pair.front_x && pair.ident_y == pair.front_y) begin
         coincident_sent++;
      end
   endtask

   task automatic stop_sending();
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic send_points(input int rx, input int ry, input int fx, input int fy);
      req_type pair;
      pair.ident_x = COORD_BITS'(rx);
      pair.ident_y = COORD_BITS'(ry);
      pair.front_x = COORD_BITS'(fx);
      pair.front_y = COORD_BITS'(fy);
      send_marker_pair(pair, 0);
   endtask

   // A random marker pair. About a third of the pairs look like a real marker: two points
   // close together somewhere in the frame. The rest are fully random, coinciding,
   // axis aligned or pushed to the corners of the coordinate range.
   function automatic req_type random_marker_pair();
      req_type pair;
      int      flavor;
      pair.ident_x = COORD_BITS'($urandom());
      pair.ident_y = COORD_BITS'($urandom());
      pair.front_x = COORD_BITS'($urandom());
      pair.front_y = COORD_BITS'($urandom());
      flavor = $urandom_range(99);
      if (flavor < 35) begin
         // Fully random points already.
      end else if (flavor < 70) begin
         pair.front_x = pair.ident_x + COORD_BITS'($urandom_range(1023)) - COORD_BITS'(512);
         pair.front_y = pair.ident_y + COORD_BITS'($urandom_range(1023)) - COORD_BITS'(512);
      end else if (flavor < 78) begin
         pair.front_x = pair.ident_x;
         pair.front_y = pair.ident_y;
      end else if (flavor < 88) begin
         if ($urandom_range(1)) begin
            pair.front_x = pair.ident_x;
         end else begin
            pair.front_y = pair.ident_y;
         end
      end else begin
         pair.ident_x = $urandom_range(1) ? COORD_BITS'($urandom_range(3)) : ~COORD_BITS'($urandom_range(3));
         pair.ident_y = $urandom_range(1) ? COORD_BITS'($urandom_range(3)) : ~COORD_BITS'($urandom_range(3));
         pair.front_x = $urandom_range(1) ? COORD_BITS'($urandom_range(3)) : ~COORD_BITS'($urandom_range(3));
         pair.front_y = $urandom_range(1) ? COORD_BITS'($urandom_range(3)) : ~COORD_BITS'($urandom_range(3));
      end
      return pair;
   endfunction

   // Results can not be held off, so each strobe is checked at the edge that ends it.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result, heading", rsp_data.heading, -1);
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (rsp_data.center_x !== want.center_x) begin
               report_mismatch("center_x", rsp_data.center_x, want.center_x);
            end
            if (rsp_data.center_y !== want.center_y) begin
               report_mismatch("center_y", rsp_data.center_y, want.center_y);
            end
            if (rsp_data.heading !== want.heading) begin
               report_mismatch("heading", rsp_data.heading, want.heading);
            end
         end
      end
   end

   // Corners of the coordinate range, including the largest possible deltas.
   task automatic test_extreme_coordinates();
      send_points(0, 0, 16'hFFFF, 16'hFFFF);
      send_points(16'hFFFF, 16'hFFFF, 0, 0);
      send_points(0, 16'hFFFF, 16'hFFFF, 0);
      send_points(16'hFFFF, 0, 0, 16'hFFFF);
      send_points(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
      // A vector one step left of straight up rounds to a full turn and wraps to zero.
      send_points(16'h8000, 16'hFFFF, 16'h7FFF, 0);
      send_points(16'h7FFF, 16'hFFFF, 16'h8000, 0);
   endtask

   // The four compass points, the diagonals and both pre-rotation quadrants.
   task automatic test_compass_directions();
      send_points(1000, 1000, 1000, 900);
      send_points(1000, 1000, 1100, 1000);
      send_points(1000, 1000, 1000, 1100);
      send_points(1000, 1000, 900, 1000);
      send_points(1000, 1000, 1100, 900);
      send_points(1000, 1000, 1100, 1100);
      send_points(1000, 1000, 900, 1100);
      send_points(1000, 1000, 900, 900);
      send_points(5000, 5000, 5001, 5000);
      send_points(5000, 5000, 4999, 5001);
      send_points(5000, 5000, 5001, 5001);
   endtask

   // Coinciding points have no direction and must report a heading of 180 degrees.
   task automatic test_coinciding_points();
      send_points(0, 0, 0, 0);
      send_points(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_points(16'h1234, 16'hBEEF, 16'h1234, 16'hBEEF);
      stop_sending();
   endtask

   task automatic test_random_stream(input int gap_pct, input int count);
      repeat (count) begin
         send_marker_pair(random_marker_pair(), gap_pct);
      end
      stop_sending();
   endtask

   // The sender holds back until the pipeline has delivered every pending result.
   task automatic test_pause_until_drained();
      stop_sending();
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_data        = '0;
      mismatch_count  = 0;
      pairs_sent      = 0;
      coincident_sent = 0;
      results_checked = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extreme_coordinates();
      test_compass_directions();
      test_coinciding_points();
      test_random_stream(38, 320);
      test_pause_until_drained();
      test_random_stream(51, 320);
      test_random_stream(0, 310);

      // Let everything in flight come out, then watch for stray strobes.
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      if (expected_results.size() != 0) begin
         report_mismatch("results never delivered", 0, expected_results.size());
      end

      $display("Sent %0d marker pairs (%0d with coinciding points) and checked %0d results,",
               pairs_sent, coincident_sent, results_checked);
      $display("with sparse, dense and gap-free input streams and one full pipeline drain.");
      if (mismatch_count == 0) begin
         $display("[marker_pair_center_heading] OK");
      end else begin
         $display("%0d mismatches found.", mismatch_count);
         $display("[marker_pair_center_heading] ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/mpch_pkg.sv
rtl/core/mpch_front.sv
rtl/core/mpch_cell.sv
rtl/core/mpch_back.sv
rtl/core/marker_pair_center_heading.sv
tb/marker_pair_center_heading_tb.sv
